// ===== rtl/core/cvsd_pkg.sv =====
`default_nettype none
package cvsd_pkg;

  localparam logic [10:0] IdDashboard = 11'h715;
  localparam logic [10:0] IdBody      = 11'h60D;
  localparam logic [10:0] IdTorque    = 11'h181;
  localparam logic [10:0] IdEngine    = 11'h551;
  localparam logic [10:0] IdBrake     = 11'h354;
  localparam logic [10:0] IdSupply    = 11'h625;

  localparam logic [1:0] RegFlush    = 2'd0;
  localparam logic [1:0] RegMinSpeed = 2'd1;
  localparam logic [1:0] RegFuelUnit = 2'd2;

  localparam logic [15:0] FlushReset    = 16'd300;
  localparam logic [15:0] MinSpeedReset = 16'd3000;
  localparam logic [7:0]  FuelUnitReset = 8'd80;

  localparam logic [2:0] ModeOff     = 3'd0;
  localparam logic [2:0] ModeLimiter = 3'd1;
  localparam logic [2:0] ModeCruise  = 3'd4;

  // numerator up to 2^24*2^8*3.6e6 < 2^54; divisor up to 2^48
  localparam int NumW = 56;
  localparam int DenW = 48;
  localparam int QW   = 17;
  localparam int StepW = 6;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch beat and decode it
    logic mul_start; // start numerator/denominator products
    logic mul_step;
    logic div_start;
    logic div_step;
    logic div_sel;   // 0 per hour, 1 per distance
    logic wr_hour;
    logic wr_dist;
    logic flush_done;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_calc;
    logic dist_ok;
    logic mul_done;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/can_vehicle_signal_decoder.sv =====
// Flow: an accepted beat is decoded into the output registers, then StCheck and StOut follow;
// an engine frame that flushes fuel figures adds 16 multiply steps and two 56-step divisions.
// Throughput: one frame at a time (in_stall_o is high outside StIdle); the next beat is
// taken the cycle after a result is accepted by the output.
// Reset (rst_ni low, async): signals to their defaults, registers to 300/3000/80.
`default_nettype none
module can_vehicle_signal_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [10:0]  frame_id_i,
  input  wire logic [31:0]  stamp_ms_i,
  input  wire logic [7:0]   byte0_i,
  input  wire logic [7:0]   byte1_i,
  input  wire logic [7:0]   byte2_i,
  input  wire logic [7:0]   byte3_i,
  input  wire logic [7:0]   byte4_i,
  input  wire logic [7:0]   byte5_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [23:0]       odometer_km_o,
  output logic [15:0]       speed_centi_kmh_o,
  output logic [15:0]       rpm_o,
  output logic signed [8:0] coolant_temp_c_o,
  output logic signed [8:0] outside_temp_c_o,
  output logic [3:0]        oil_gauge_o,
  output logic [6:0]        fuel_gauge_o,
  output logic [7:0]        limiter_setpoint_o,
  output logic [7:0]        status_flags_o,
  output logic [7:0]        battery_sixteenths_v_o,
  output logic [15:0]       fuel_centi_l_per_h_o,
  output logic signed [16:0] fuel_centi_l_per_100km_o
);

  logic [15:0] flush_q, minspd_q;
  logic [7:0]  unit_q;
  logic        wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q  <= cvsd_pkg::FlushReset;
      minspd_q <= cvsd_pkg::MinSpeedReset;
      unit_q   <= cvsd_pkg::FuelUnitReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        cvsd_pkg::RegFlush:    flush_q  <= pwdata[15:0];
        cvsd_pkg::RegMinSpeed: minspd_q <= pwdata[15:0];
        cvsd_pkg::RegFuelUnit: unit_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cvsd_pkg::RegFlush:    prdata = {16'd0, flush_q};
      cvsd_pkg::RegMinSpeed: prdata = {16'd0, minspd_q};
      cvsd_pkg::RegFuelUnit: prdata = {24'd0, unit_q};
      default:               prdata = '0;
    endcase
  end

  cvsd_pkg::dp_cmd_t cmd;
  cvsd_pkg::dp_sts_t sts;

  cvsd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  cvsd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .flush_i(flush_q), .min_speed_i(minspd_q), .unit_i(unit_q),
    .frame_id_i, .stamp_ms_i, .byte0_i, .byte1_i, .byte2_i, .byte3_i,
    .byte4_i, .byte5_i,
    .odometer_km_o, .speed_centi_kmh_o, .rpm_o, .coolant_temp_c_o,
    .outside_temp_c_o, .oil_gauge_o, .fuel_gauge_o, .limiter_setpoint_o,
    .status_flags_o, .battery_sixteenths_v_o, .fuel_centi_l_per_h_o,
    .fuel_centi_l_per_100km_o
  );

endmodule
`default_nettype wire

// ===== rtl/core/cvsd_datapath.sv =====
`default_nettype none
module cvsd_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cvsd_pkg::dp_cmd_t cmd_i,
  output cvsd_pkg::dp_sts_t     sts_o,
  input  wire logic [15:0]      flush_i,
  input  wire logic [15:0]      min_speed_i,
  input  wire logic [7:0]       unit_i,
  input  wire logic [10:0]      frame_id_i,
  input  wire logic [31:0]      stamp_ms_i,
  input  wire logic [7:0]       byte0_i,
  input  wire logic [7:0]       byte1_i,
  input  wire logic [7:0]       byte2_i,
  input  wire logic [7:0]       byte3_i,
  input  wire logic [7:0]       byte4_i,
  input  wire logic [7:0]       byte5_i,
  output logic [23:0]           odometer_km_o,
  output logic [15:0]           speed_centi_kmh_o,
  output logic [15:0]           rpm_o,
  output logic signed [8:0]     coolant_temp_c_o,
  output logic signed [8:0]     outside_temp_c_o,
  output logic [3:0]            oil_gauge_o,
  output logic [6:0]            fuel_gauge_o,
  output logic [7:0]            limiter_setpoint_o,
  output logic [7:0]            status_flags_o,
  output logic [7:0]            battery_sixteenths_v_o,
  output logic [15:0]           fuel_centi_l_per_h_o,
  output logic signed [16:0]    fuel_centi_l_per_100km_o
);

  localparam int NumW = cvsd_pkg::NumW;
  localparam int DenW = cvsd_pkg::DenW;
  localparam int QW   = cvsd_pkg::QW;

  logic [23:0] odo_q;
  logic [15:0] speed_q, rpm_q;
  logic [8:0]  cool_q, outs_q;
  logic [3:0]  oil_q;
  logic [6:0]  fg_q;
  logic [7:0]  lim_q, flags_q, batt_q;
  logic [31:0] last_stamp_q;
  logic        stamp_valid_q;
  logic [7:0]  last_cnt_q;
  logic [23:0] fuel_sum_q;
  logic [31:0] time_sum_q;
  logic [15:0] rate_h_q;
  logic [16:0] rate_d_q;

  logic [7:0] flags_d;
  logic [31:0] dt;
  logic [7:0]  steps;
  logic [24:0] fuel_add;
  logic [32:0] time_add;
  logic [23:0] fuel_new;
  logic [31:0] time_new;

  always_comb begin
    dt       = stamp_ms_i - last_stamp_q;
    steps    = byte1_i - last_cnt_q;
    fuel_add = {1'b0, fuel_sum_q} + {17'd0, steps};
    time_add = {1'b0, time_sum_q} + {1'b0, dt};
    fuel_new = fuel_add[24] ? 24'hFFFFFF : fuel_add[23:0];
    time_new = time_add[32] ? 32'hFFFFFFFF : time_add[31:0];
    flags_d  = flags_q;
    unique case (frame_id_i)
      cvsd_pkg::IdBody: begin
        flags_d[0] = byte2_i[3];
        flags_d[1] = byte2_i[4];
        flags_d[2] = byte0_i[3];
        flags_d[3] = byte0_i[4];
        flags_d[4] = byte0_i[7];
      end
      cvsd_pkg::IdSupply: flags_d[5] = byte3_i[5];
      cvsd_pkg::IdEngine: begin
        if (byte5_i[6:4] == cvsd_pkg::ModeOff) begin
          flags_d[7:6] = 2'b00;
        end else if (byte5_i[6:4] == cvsd_pkg::ModeLimiter) begin
          flags_d[7] = 1'b1;
        end else if (byte5_i[6:4] == cvsd_pkg::ModeCruise) begin
          flags_d[6] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic need_calc_q;

  // multiply stage: vol = fuel*unit; numerators; den = time*speed (serial 16 steps)
  logic [31:0] vol_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [15:0] mspd_q;
  logic [4:0]  mcnt_q;

  // divider: restoring, one bit per step over NumW bits
  logic [NumW-1:0] dnum_q;
  logic [DenW:0]   rem_q;
  logic [NumW-1:0] quo_q;
  logic [cvsd_pkg::StepW-1:0] dcnt_q;
  logic [DenW:0]   rem_sh, rem_sub;

  always_comb begin
    rem_sh  = {rem_q[DenW-1:0], dnum_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, (cmd_i.div_sel ? den_q : {16'd0, time_sum_q})};
  end

  logic [15:0] qsat;
  assign qsat = (|quo_q[NumW-1:16]) ? 16'hFFFF : quo_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odo_q <= '0; speed_q <= '0; rpm_q <= '0; cool_q <= '0; outs_q <= '0;
      oil_q <= 4'd6; fg_q <= 7'd45; lim_q <= '0; flags_q <= '0; batt_q <= 8'd196;
      last_stamp_q <= '0; stamp_valid_q <= 1'b0; last_cnt_q <= '0;
      fuel_sum_q <= '0; time_sum_q <= '0; rate_h_q <= '0; rate_d_q <= '0;
      need_calc_q <= 1'b0;
      mcnt_q <= '0; dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        flags_q <= flags_d;
        unique case (frame_id_i)
          cvsd_pkg::IdDashboard: begin
            odo_q <= {byte0_i, byte1_i, byte2_i};
            oil_q <= byte3_i[5:2];
            fg_q  <= byte4_i[7:1];
          end
          cvsd_pkg::IdBody: outs_q <= {1'b0, byte4_i} - 9'd40;
          cvsd_pkg::IdTorque: rpm_q <= {byte0_i, byte1_i};
          cvsd_pkg::IdBrake: speed_q <= {byte0_i, byte1_i};
          cvsd_pkg::IdSupply: batt_q <= byte2_i;
          cvsd_pkg::IdEngine: begin
            cool_q <= {1'b0, byte0_i} - 9'd40;
            lim_q  <= byte4_i;
            last_stamp_q <= stamp_ms_i;
            last_cnt_q   <= byte1_i;
            stamp_valid_q <= 1'b1;
            need_calc_q <= stamp_valid_q && (time_new > {16'd0, flush_i});
            if (stamp_valid_q) begin
              fuel_sum_q <= fuel_new;
              time_sum_q <= time_new;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.mul_start) begin
        mcnt_q <= '0;
      end else if (cmd_i.mul_step) begin
        mcnt_q <= mcnt_q + 5'd1;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.wr_hour) rate_h_q <= qsat;
      if (cmd_i.wr_dist) rate_d_q <= sts_o.dist_ok ? {1'b0, qsat} : 17'h1FFFF;
      if (cmd_i.flush_done) begin
        fuel_sum_q <= '0;
        time_sum_q <= '0;
        need_calc_q <= 1'b0;
      end
    end
  end

  // serial multiplies: one 32-bit row of time*speed per step, vol*const at the end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      vol_q  <= fuel_sum_q * unit_i;
      den_q  <= '0;
      mspd_q <= speed_q;
    end else if (cmd_i.mul_step) begin
      if (mspd_q[0]) den_q <= den_q + ({16'd0, time_sum_q} << mcnt_q[3:0]);
      mspd_q <= mspd_q >> 1;
    end
    if (cmd_i.div_start) begin
      dnum_q <= cmd_i.div_sel ? (NumW'(vol_q) * NumW'(22'd3600000))
                              : (NumW'(vol_q) * NumW'(9'd360));
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      dnum_q <= dnum_q << 1;
      if (!rem_sub[DenW]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign num_q = dnum_q;

  assign sts_o.need_calc = need_calc_q;
  assign sts_o.dist_ok   = speed_q > min_speed_i;
  assign sts_o.mul_done  = mcnt_q == 5'd16;
  assign sts_o.div_done  = dcnt_q == cvsd_pkg::StepW'(NumW);

  assign odometer_km_o            = odo_q;
  assign speed_centi_kmh_o        = speed_q;
  assign rpm_o                    = rpm_q;
  assign coolant_temp_c_o         = cool_q;
  assign outside_temp_c_o         = outs_q;
  assign oil_gauge_o              = oil_q;
  assign fuel_gauge_o             = fg_q;
  assign limiter_setpoint_o       = lim_q;
  assign status_flags_o           = flags_q;
  assign battery_sixteenths_v_o   = batt_q;
  assign fuel_centi_l_per_h_o     = rate_h_q;
  assign fuel_centi_l_per_100km_o = rate_d_q;

  logic unused;
  assign unused = ^{num_q[0], QW};

endmodule
`default_nettype wire

// ===== rtl/core/cvsd_ctrl.sv =====
`default_nettype none
module cvsd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire cvsd_pkg::dp_sts_t sts_i,
  output cvsd_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StCheck = 7'b0000010,
    StMul   = 7'b0000100,
    StDivH  = 7'b0001000,
    StDivD  = 7'b0010000,
    StOut   = 7'b0100000,
    StPrep  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   first_q, first_d;

  always_comb begin
    state_d = state_q;
    first_d = 1'b0;
    cmd_o   = '0;
    in_stall_o  = state_q != StIdle;
    out_valid_o = state_q == StOut;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = StCheck;
      end
      StCheck: if (sts_i.need_calc) begin
        cmd_o.mul_start = 1'b1;
        state_d = StMul;
      end else begin
        state_d = StOut;
      end
      StMul: if (sts_i.mul_done) begin
        cmd_o.div_start = 1'b1;
        state_d = StDivH;
      end else begin
        cmd_o.mul_step = 1'b1;
      end
      StDivH: if (sts_i.div_done) begin
        cmd_o.wr_hour = 1'b1;
        state_d = StPrep;
      end else begin
        cmd_o.div_step = 1'b1;
      end
      StPrep: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = StDivD;
      end
      StDivD: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.wr_dist = 1'b1;
          cmd_o.flush_done = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  logic unused;
  assign unused = first_q;

endmodule
`default_nettype wire
